>>> design/quadratic_root_solver_unit_defines.svh
// Assertion macros shared by the checker of the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
`default_nettype none

package qrs_pkg;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_ALL  = 2'd1,
        ST_ONE  = 2'd2,
        ST_TWO  = 2'd3
    } status_t;

    typedef struct packed {
        status_t status;
        logic    den_neg;
        logic    neg_first;
        logic    neg_second;
    } ctl_t;

    localparam int USER_W = 3;

endpackage

`default_nettype wire

>>> design/qrs_front.sv
// Front end: sign split, split multiplies, discriminant and case decision.
`default_nettype none

module qrs_front #(
    parameter int COEF_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [COEF_WIDTH-1:0] coef_quad,
    input  logic [COEF_WIDTH-1:0] coef_lin,
    input  logic [COEF_WIDTH-1:0] coef_const,
    output logic                  out_vld,
    output logic [2*COEF_WIDTH:0] disc,
    output logic [COEF_WIDTH:0]   base,
    output logic [COEF_WIDTH:0]   den,
    output qrs_pkg::ctl_t         ctl
);
    import qrs_pkg::*;

    localparam int W  = COEF_WIDTH;
    localparam int LO = (W + 1) / 2;
    localparam int HI = W - LO;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;

    logic         na, nb, nc;
    logic [W-1:0] ma, mb, mc;

    logic         s1_vld_reg;
    logic [W-1:0] s1_ma_reg, s1_mb_reg, s1_mc_reg;
    logic         s1_na_reg, s1_nb_reg, s1_nc_reg;

    logic               s2_vld_reg;
    logic [2*LO-1:0]    s2_bb_ll_reg, s2_ac_ll_reg;
    logic [LO+HI-1:0]   s2_bb_lh_reg, s2_ac_lh_reg, s2_ac_hl_reg;
    logic [2*HI-1:0]    s2_bb_hh_reg, s2_ac_hh_reg;
    logic [W-1:0]       s2_ma_reg, s2_mb_reg;
    logic               s2_na_reg, s2_nb_reg, s2_nc_reg;
    logic               s2_az_reg, s2_bz_reg, s2_cz_reg;
    logic [W:0]         s2_negb_reg, s2_negc_reg;

    logic          s3_vld_reg;
    logic [PW-1:0] s3_bb_reg, s3_ac_reg;
    logic [W-1:0]  s3_ma_reg, s3_mb_reg;
    logic          s3_na_reg, s3_nb_reg;
    logic          s3_az_reg, s3_bz_reg, s3_cz_reg, s3_acpos_reg;
    logic [W:0]    s3_negb_reg, s3_negc_reg;

    logic          out_vld_reg;
    logic [DW-1:0] disc_reg, disc_next;
    logic [W:0]    base_reg, base_next;
    logic [W:0]    den_reg, den_next;
    ctl_t          ctl_reg, ctl_next;

    logic [DW-1:0] bb_ext, ac4;
    logic          bb_lt, bb_eq;

    assign na = coef_quad[W-1];
    assign nb = coef_lin[W-1];
    assign nc = coef_const[W-1];
    assign ma = na ? (~coef_quad + W'(1)) : coef_quad;
    assign mb = nb ? (~coef_lin + W'(1)) : coef_lin;
    assign mc = nc ? (~coef_const + W'(1)) : coef_const;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ma_reg <= ma;
            s1_mb_reg <= mb;
            s1_mc_reg <= mc;
            s1_na_reg <= na;
            s1_nb_reg <= nb;
            s1_nc_reg <= nc;

            s2_bb_ll_reg <= s1_mb_reg[LO-1:0] * s1_mb_reg[LO-1:0];
            s2_bb_lh_reg <= s1_mb_reg[LO-1:0] * s1_mb_reg[W-1:LO];
            s2_bb_hh_reg <= s1_mb_reg[W-1:LO] * s1_mb_reg[W-1:LO];
            s2_ac_ll_reg <= s1_ma_reg[LO-1:0] * s1_mc_reg[LO-1:0];
            s2_ac_lh_reg <= s1_ma_reg[LO-1:0] * s1_mc_reg[W-1:LO];
            s2_ac_hl_reg <= s1_ma_reg[W-1:LO] * s1_mc_reg[LO-1:0];
            s2_ac_hh_reg <= s1_ma_reg[W-1:LO] * s1_mc_reg[W-1:LO];
            s2_ma_reg    <= s1_ma_reg;
            s2_mb_reg    <= s1_mb_reg;
            s2_na_reg    <= s1_na_reg;
            s2_nb_reg    <= s1_nb_reg;
            s2_nc_reg    <= s1_nc_reg;
            s2_az_reg    <= (s1_ma_reg == '0);
            s2_bz_reg    <= (s1_mb_reg == '0);
            s2_cz_reg    <= (s1_mc_reg == '0);
            s2_negb_reg  <= s1_nb_reg ? {1'b0, s1_mb_reg} : (~{1'b0, s1_mb_reg} + (W+1)'(1));
            s2_negc_reg  <= s1_nc_reg ? {1'b0, s1_mc_reg} : (~{1'b0, s1_mc_reg} + (W+1)'(1));

            s3_bb_reg <= (PW'(s2_bb_hh_reg) << (2 * LO)) + (PW'(s2_bb_lh_reg) << (LO + 1))
                         + PW'(s2_bb_ll_reg);
            s3_ac_reg <= (PW'(s2_ac_hh_reg) << (2 * LO))
                         + ((PW'(s2_ac_lh_reg) + PW'(s2_ac_hl_reg)) << LO)
                         + PW'(s2_ac_ll_reg);
            s3_ma_reg    <= s2_ma_reg;
            s3_mb_reg    <= s2_mb_reg;
            s3_na_reg    <= s2_na_reg;
            s3_nb_reg    <= s2_nb_reg;
            s3_az_reg    <= s2_az_reg;
            s3_bz_reg    <= s2_bz_reg;
            s3_cz_reg    <= s2_cz_reg;
            s3_acpos_reg <= !s2_cz_reg && (s2_na_reg == s2_nc_reg);
            s3_negb_reg  <= s2_negb_reg;
            s3_negc_reg  <= s2_negc_reg;

            disc_reg <= disc_next;
            base_reg <= base_next;
            den_reg  <= den_next;
            ctl_reg  <= ctl_next;
        end
    end

    assign bb_ext = DW'(s3_bb_reg);
    assign ac4    = DW'(s3_ac_reg) << 2;
    assign bb_lt  = bb_ext < ac4;
    assign bb_eq  = bb_ext == ac4;

    always_comb
    begin
        disc_next           = s3_acpos_reg ? (bb_ext - ac4) : (bb_ext + ac4);
        ctl_next.neg_first  = 1'b0;
        ctl_next.neg_second = 1'b0;
        if (s3_az_reg)
        begin
            base_next        = s3_negc_reg;
            den_next         = {1'b0, s3_mb_reg};
            ctl_next.den_neg = s3_nb_reg;
            if (s3_bz_reg)
            begin
                ctl_next.status = s3_cz_reg ? ST_ALL : ST_NONE;
            end
            else
            begin
                ctl_next.status = ST_ONE;
            end
        end
        else
        begin
            base_next        = s3_negb_reg;
            den_next         = {s3_ma_reg, 1'b0};
            ctl_next.den_neg = s3_na_reg;
            if (s3_acpos_reg && bb_lt)
            begin
                ctl_next.status = ST_NONE;
            end
            else if (s3_acpos_reg ? bb_eq : (s3_bz_reg && s3_cz_reg))
            begin
                ctl_next.status = ST_ONE;
            end
            else
            begin
                ctl_next.status = ST_TWO;
            end
        end
    end

    assign out_vld = out_vld_reg;
    assign disc    = disc_reg;
    assign base    = base_reg;
    assign den     = den_reg;
    assign ctl     = ctl_reg;

endmodule

`default_nettype wire

>>> design/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module qrs_sqrt #(
    parameter int COEF_WIDTH = 32,
    parameter int SIDE_W     = 66
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [2*COEF_WIDTH:0] radicand,
    input  logic [SIDE_W-1:0]     in_side,
    input  qrs_pkg::ctl_t         in_ctl,
    output logic                  out_vld,
    output logic [COEF_WIDTH:0]   root,
    output logic [SIDE_W-1:0]     out_side,
    output qrs_pkg::ctl_t         out_ctl
);
    import qrs_pkg::*;

    localparam int SW   = COEF_WIDTH + 1;
    localparam int RW   = 2 * SW;
    localparam int REMW = SW + 2;
    localparam int SHW  = REMW + 2;

    logic              vld_reg  [0:SW-1];
    logic [RW-1:0]     rad_reg  [0:SW-1];
    logic [REMW-1:0]   rem_reg  [0:SW-1];
    logic [SW-1:0]     root_reg [0:SW-1];
    logic [SIDE_W-1:0] side_reg [0:SW-1];
    ctl_t              ctl_reg  [0:SW-1];

    for (genvar k = 0; k < SW; k++)
    begin : g_stage
        logic              vld_in;
        logic [RW-1:0]     rad_in;
        logic [REMW-1:0]   rem_in;
        logic [SW-1:0]     root_in;
        logic [SIDE_W-1:0] side_in;
        ctl_t              ctl_in;
        logic [SHW-1:0]    rem_sh, trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rad_in  = RW'(radicand);
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
            assign ctl_in  = in_ctl;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
            assign ctl_in  = ctl_reg[k-1];
        end

        assign rem_sh = {rem_in, rad_in[RW-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_in[RW-3:0], 2'b00};
                rem_reg[k]  <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
                root_reg[k] <= {root_in[SW-2:0], ge};
                side_reg[k] <= side_in;
                ctl_reg[k]  <= ctl_in;
            end
        end
    end

    assign out_vld  = vld_reg[SW-1];
    assign root     = root_reg[SW-1];
    assign out_side = side_reg[SW-1];
    assign out_ctl  = ctl_reg[SW-1];

endmodule

`default_nettype wire

>>> design/qrs_div.sv
// Pipelined two-lane restoring divider with a shared divisor, one bit per stage.
`default_nettype none

module qrs_div #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [COEF_WIDTH+1:0]                num_first,
    input  logic [COEF_WIDTH+1:0]                num_second,
    input  logic [COEF_WIDTH:0]                  den,
    input  qrs_pkg::ctl_t                        in_ctl,
    output logic                                 out_vld,
    output logic [COEF_WIDTH+FRAC_BITS+1:0]      quo_first,
    output logic [COEF_WIDTH+FRAC_BITS+1:0]      quo_second,
    output qrs_pkg::ctl_t                        out_ctl
);
    import qrs_pkg::*;

    localparam int DENW = COEF_WIDTH + 1;
    localparam int QW   = COEF_WIDTH + 2 + FRAC_BITS;

    logic                 vld_reg [0:QW-1];
    logic [1:0][QW-1:0]   num_reg [0:QW-1];
    logic [1:0][DENW-1:0] rem_reg [0:QW-1];
    logic [DENW-1:0]      den_reg [0:QW-1];
    ctl_t                 ctl_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic                 vld_in;
        logic [1:0][QW-1:0]   num_in, num_out;
        logic [1:0][DENW-1:0] rem_in, rem_out;
        logic [DENW-1:0]      den_in;
        ctl_t                 ctl_in;

        if (k == 0)
        begin : g_first
            assign vld_in    = in_vld;
            assign num_in[0] = QW'(num_first) << FRAC_BITS;
            assign num_in[1] = QW'(num_second) << FRAC_BITS;
            assign rem_in    = '0;
            assign den_in    = den;
            assign ctl_in    = in_ctl;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k-1];
            assign num_in = num_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign ctl_in = ctl_reg[k-1];
        end

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                logic [DENW:0] rem_sh;
                logic          ge;
                rem_sh     = {rem_in[l], num_in[l][QW-1]};
                ge         = rem_sh >= {1'b0, den_in};
                rem_out[l] = ge ? DENW'(rem_sh - {1'b0, den_in}) : DENW'(rem_sh);
                num_out[l] = {num_in[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= num_out;
                rem_reg[k] <= rem_out;
                den_reg[k] <= den_in;
                ctl_reg[k] <= ctl_in;
            end
        end
    end

    assign out_vld    = vld_reg[QW-1];
    assign quo_first  = num_reg[QW-1][0];
    assign quo_second = num_reg[QW-1][1];
    assign out_ctl    = ctl_reg[QW-1];

endmodule

`default_nettype wire

>>> design/quadratic_root_solver_unit.sv
// Top level of the pipelined fixed-point quadratic root solver.
//
// Channel  Direction  Handshake                  Content
// s_axis   in         s_tvalid / s_tready        coefficients a, b, c
// m_axis   out        m_tvalid / m_tready        status, two roots, overflow
//
// One request is taken every cycle while the output buffer has room; a request
// passes through the front end, square root, combine register, divider and final
// register, the square root and divider pipelines giving one bit per stage.
// Reset clears all valid bits and the output buffer; no clearing pass is needed.
// The pipeline advances as a whole while its two-entry output buffer has room, so
// a request is still taken while one result waits, and a stall loses nothing.
`default_nettype none

module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // coef_quad, coef_lin, coef_const, zero padding
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // root_first, root_second, zero padding
    output logic [((2*COEF_WIDTH+7)/8)*8-1:0]     m_tdata,
    // root_status (2 bits), overflow
    output logic [qrs_pkg::USER_W-1:0]            m_tuser
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int ODW    = ((2 * W + 7) / 8) * 8;
    localparam int SW     = W + 1;
    localparam int NMW    = W + 2;
    localparam int SUMW   = W + 3;
    localparam int QW     = W + 2 + FRAC_BITS;
    localparam int SIDE_W = 2 * (W + 1);

    logic en;

    logic          fr_vld;
    logic [2*W:0]  fr_disc;
    logic [W:0]    fr_base, fr_den;
    ctl_t          fr_ctl;

    logic              sq_vld;
    logic [SW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;
    ctl_t              sq_ctl;

    logic           cmb_vld_reg;
    logic [NMW-1:0] cmb_first_reg, cmb_second_reg;
    logic [W:0]     cmb_den_reg;
    ctl_t           cmb_ctl_reg, cmb_ctl_next;
    logic [SUMW-1:0] sum_first, sum_second, base_ext, s_add;

    logic          dv_vld;
    logic [QW-1:0] dv_first, dv_second;
    ctl_t          dv_ctl;

    logic          fin_vld_reg;
    logic [W-1:0]  fin_first_reg, fin_second_reg, fin_first_next, fin_second_next;
    status_t       fin_status_reg;
    logic          fin_ovf_reg, fin_ovf_next;

    logic [1:0]    cnt_reg;
    logic [W-1:0]  out_first_reg, out_second_reg, skd_first_reg, skd_second_reg;
    status_t       out_status_reg, skd_status_reg;
    logic          out_ovf_reg, skd_ovf_reg;
    logic          push, pop;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (s_tvalid),
        .coef_quad  (s_tdata[W-1:0]),
        .coef_lin   (s_tdata[2*W-1:W]),
        .coef_const (s_tdata[3*W-1:2*W]),
        .out_vld    (fr_vld),
        .disc       (fr_disc),
        .base       (fr_base),
        .den        (fr_den),
        .ctl        (fr_ctl)
    );

    qrs_sqrt #(.COEF_WIDTH(COEF_WIDTH), .SIDE_W(SIDE_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (fr_vld),
        .radicand (fr_disc),
        .in_side  ({fr_base, fr_den}),
        .in_ctl   (fr_ctl),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side),
        .out_ctl  (sq_ctl)
    );

    assign base_ext   = {{2{sq_side[SIDE_W-1]}}, sq_side[SIDE_W-1:W+1]};
    assign s_add      = (sq_ctl.status == ST_TWO) ? SUMW'(sq_root) : '0;
    assign sum_first  = base_ext + s_add;
    assign sum_second = base_ext - s_add;

    always_comb
    begin
        cmb_ctl_next            = sq_ctl;
        cmb_ctl_next.neg_first  = sum_first[SUMW-1] ^ sq_ctl.den_neg;
        cmb_ctl_next.neg_second = sum_second[SUMW-1] ^ sq_ctl.den_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmb_vld_reg <= 1'b0;
            fin_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            cmb_vld_reg <= sq_vld;
            fin_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmb_first_reg  <= sum_first[SUMW-1] ? NMW'(~sum_first + SUMW'(1))
                                                : NMW'(sum_first);
            cmb_second_reg <= sum_second[SUMW-1] ? NMW'(~sum_second + SUMW'(1))
                                                 : NMW'(sum_second);
            cmb_den_reg    <= sq_side[W:0];
            cmb_ctl_reg    <= cmb_ctl_next;
        end
    end

    qrs_div #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (cmb_vld_reg),
        .num_first  (cmb_first_reg),
        .num_second (cmb_second_reg),
        .den        (cmb_den_reg),
        .in_ctl     (cmb_ctl_reg),
        .out_vld    (dv_vld),
        .quo_first  (dv_first),
        .quo_second (dv_second),
        .out_ctl    (dv_ctl)
    );

    always_comb
    begin
        logic [QW-1:0] lim1, lim2;
        logic          sat1, sat2, use1, use2;
        logic [W-1:0]  v1, v2;
        lim1 = (QW'(1) << (W - 1)) - QW'(!dv_ctl.neg_first);
        lim2 = (QW'(1) << (W - 1)) - QW'(!dv_ctl.neg_second);
        sat1 = dv_first > lim1;
        sat2 = dv_second > lim2;
        use1 = (dv_ctl.status == ST_ONE) || (dv_ctl.status == ST_TWO);
        use2 = (dv_ctl.status == ST_TWO);
        v1   = sat1 ? lim1[W-1:0] : dv_first[W-1:0];
        v2   = sat2 ? lim2[W-1:0] : dv_second[W-1:0];
        v1   = dv_ctl.neg_first ? (~v1 + W'(1)) : v1;
        v2   = dv_ctl.neg_second ? (~v2 + W'(1)) : v2;
        fin_first_next  = use1 ? v1 : '0;
        fin_second_next = use2 ? v2 : '0;
        fin_ovf_next    = (use1 && sat1) || (use2 && sat2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_first_reg  <= fin_first_next;
            fin_second_reg <= fin_second_next;
            fin_status_reg <= dv_ctl.status;
            fin_ovf_reg    <= fin_ovf_next;
        end
    end

    assign push = en && fin_vld_reg;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((push && (cnt_reg == 2'd0)) || (push && pop && (cnt_reg == 2'd1)))
        begin
            out_first_reg  <= fin_first_reg;
            out_second_reg <= fin_second_reg;
            out_status_reg <= fin_status_reg;
            out_ovf_reg    <= fin_ovf_reg;
        end
        else if (pop && (cnt_reg == 2'd2))
        begin
            out_first_reg  <= skd_first_reg;
            out_second_reg <= skd_second_reg;
            out_status_reg <= skd_status_reg;
            out_ovf_reg    <= skd_ovf_reg;
        end
        if (push && !pop && (cnt_reg == 2'd1))
        begin
            skd_first_reg  <= fin_first_reg;
            skd_second_reg <= fin_second_reg;
            skd_status_reg <= fin_status_reg;
            skd_ovf_reg    <= fin_ovf_reg;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = ODW'({out_second_reg, out_first_reg});
    assign m_tuser  = {out_ovf_reg, out_status_reg};

endmodule

`default_nettype wire

>>> design/qrs_checker.sv
// Port-level checker of the quadratic root solver and its bind.
`default_nettype none
`include "quadratic_root_solver_unit_defines.svh"

module qrs_checker #(
    parameter int COEF_WIDTH = 32
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [((2*COEF_WIDTH+7)/8)*8-1:0] m_tdata,
    input wire logic [qrs_pkg::USER_W-1:0]        m_tuser
);
    import qrs_pkg::*;

    localparam int W = COEF_WIDTH;

    `QRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `QRS_ASSERT_NOW(a_no_root_zero, m_tvalid && (m_tuser[1:0] == ST_NONE || m_tuser[1:0] == ST_ALL), m_tdata == '0, "root fields not zero without a root")
    `QRS_ASSERT_NOW(a_one_root_second, m_tvalid && m_tuser[1:0] == ST_ONE, m_tdata[2*W-1:W] == '0, "second root not zero for a single root")
    `QRS_ASSERT_NOW(a_ovf_needs_root, m_tvalid && m_tuser[2], m_tuser[1:0] == ST_ONE || m_tuser[1:0] == ST_TWO, "overflow without a root")

endmodule

bind quadratic_root_solver_unit qrs_checker #(.COEF_WIDTH(COEF_WIDTH)) u_qrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> bench/qrs_checker.sv
// Checker that predicts and compares the roots produced by the quadratic root solver.
`default_nettype none

module qrs_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          solved_count
);
    import qrs_pkg::*;

    typedef struct {
        status_t     status;
        logic [31:0] first;
        logic [31:0] second;
        logic        ovf;
    } roots_t;

    roots_t expected_roots[$];

    // Signed numerator scaled by 2^16 over a signed denominator, truncated, saturated.
    function automatic logic [31:0] scaled_quotient(input logic signed [65:0] num,
                                                    input logic signed [65:0] den,
                                                    inout logic ovf);
        logic signed [99:0] q;
        q = (100'(num) <<< 16) / 100'(den);
        if (q > 100'sh7fffffff)
        begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (q < -100'sh80000000)
        begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    function automatic roots_t solve_roots(input logic [95:0] coefs);
        logic signed [31:0]  a, b, c;
        logic signed [67:0]  disc;
        logic        [67:0]  s;
        logic        [67:0]  t;
        roots_t r;
        a = coefs[31:0];
        b = coefs[63:32];
        c = coefs[95:64];
        r = '{ST_NONE, 32'd0, 32'd0, 1'b0};
        if (a == 0)
        begin
            if (b == 0)
                r.status = (c == 0) ? ST_ALL : ST_NONE;
            else
            begin
                r.status = ST_ONE;
                r.first = scaled_quotient(-66'(c), 66'(b), r.ovf);
            end
            return r;
        end
        disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
        if (disc < 0)
            return r;
        if (disc == 0)
        begin
            r.status = ST_ONE;
            r.first = scaled_quotient(-66'(b), 66'sd2 * 66'(a), r.ovf);
            return r;
        end
        s = 0;
        for (int i = 33; i >= 0; i--)
        begin
            t = s | (68'd1 << i);
            if (t * t <= 68'(disc))
                s = t;
        end
        r.status = ST_TWO;
        r.first = scaled_quotient(-66'(b) + 66'(s), 66'sd2 * 66'(a), r.ovf);
        r.second = scaled_quotient(-66'(b) - 66'(s), 66'sd2 * 66'(a), r.ovf);
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        solved_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        roots_t e;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_roots.push_back(solve_roots(s_tdata));
            if (m_tvalid && m_tready)
            begin
                solved_count++;
                if (expected_roots.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_roots.pop_front();
                    if (m_tuser[1:0] !== e.status)
                    begin
                        $error("root_status expected %0d actual %0d", e.status, m_tuser[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== e.first)
                    begin
                        $error("root_first expected %h actual %h", e.first, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== e.second)
                    begin
                        $error("root_second expected %h actual %h", e.second, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tuser[2] !== e.ovf)
                    begin
                        $error("overflow expected %b actual %b", e.ovf, m_tuser[2]);
                        fail_count++;
                    end
                end
            end
            pending = expected_roots.size();
        end
    end
endmodule

`default_nettype wire

>>> bench/tb.sv
// Top of the quadratic root solver testbench: stimulus, flow control and verdict.
`default_nettype none

module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count, pending, solved_count;
    int          send_idle = 0, recv_stall = 0;
    bit          hold_off = 1'b0;
    int          cycle = 0;

    always #6 clk = ~clk;

    quadratic_root_solver_unit dut (.*);

    qrs_scoreboard checker_i (.*);

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 400000)
        begin
            $display("quadratic_root_solver_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return 32'(signed'($urandom_range(0, 2 ** 20)) - 2 ** 19);
            4: return 32'(signed'($urandom_range(0, 2 ** 10)) - 2 ** 9) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_coefs(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        @(posedge clk iff s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    logic [31:0] one, r1, r2;

    initial
    begin
        one = 32'h10000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: linear cases, double root, negative discriminant, overflow, extremes.
        send_coefs(0, 0, 0);
        send_coefs(0, 0, one);
        send_coefs(0, one, one);
        send_coefs(0, 1, 32'h7fffffff);
        send_coefs(0, 32'h80000000, 32'h80000000);
        send_coefs(one, 2 * one, one);
        send_coefs(one, 0, one);
        send_coefs(one, 0, -one);
        send_coefs(1, 32'h7fffffff, 32'h80000000);
        send_coefs(32'h80000000, 32'h80000000, 32'h7fffffff);
        send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_coefs(32'h80000000, 0, 32'h80000000);
        send_coefs(-one, 3 * one, 4 * one);
        send_coefs(32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_coefs(2, 32'h7fffffff, 0);
        send_coefs(one, 0, 0);
        wait_drained();
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 52 : 25) : 0;
            recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 52 : 25) : 0;
            if (phase == 0)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 170; n++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    // Build from chosen roots so two-root and double-root cases are common.
                    r1 = 32'(signed'($urandom_range(0, 64)) - 32);
                    r2 = $urandom_range(1) ? r1 : 32'(signed'($urandom_range(0, 64)) - 32);
                    send_coefs(one, -(r1 + r2) << 16, (r1 * r2) << 16);
                end
                else
                    send_coefs(pick_coef(), pick_coef(), pick_coef());
            end
            hold_off = 1'b0;
            wait_drained();
        end
        recv_stall = 0;
        repeat (100) @(posedge clk);
        $display("Covered %0d solved requests over linear, double, complex and two-root cases,",
                 solved_count);
        $display("with sender gaps, receiver stalls and a long output hold-off.");
        if (fail_count == 0)
            $display("quadratic_root_solver_unit: match");
        else
            $display("quadratic_root_solver_unit: mismatch");
        $finish;
    end
endmodule

`default_nettype wire
